[hdl/anc_payload_field_parser_assert.svh]
// Assertion macros for the ancillary payload field parser.
`ifndef ANC_PAYLOAD_FIELD_PARSER_ASSERT_SVH
`define ANC_PAYLOAD_FIELD_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define ANC_PFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ANC_PFP_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ANC_PFP_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ANC_PFP_ASSERT(label, clk, rst_n, prop, msg)
`define ANC_PFP_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ANC_PFP_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/anc_pfp_pkg.sv]
// Shared types and constants of the ancillary payload field parser.
package anc_pfp_pkg;

  localparam int HDR_BITS   = 64;
  localparam int LOC_BITS   = 32;
  localparam int WORD_BITS  = 10;
  localparam int ALIGN_BITS = 32;
  localparam int RSVD_BITS  = 22;
  localparam int BYTE_MASK  = 'hff;

  localparam int RES_DEPTH = 3;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_HDR,
    KIND_LOC,
    KIND_DID,
    KIND_SDID,
    KIND_DC,
    KIND_USER,
    KIND_CSUM,
    KIND_TRUNC
  } kind_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [15:0] ext_sequence;
    logic [15:0] payload_length;
    logic [7:0]  packet_count;
    logic [1:0]  field_code;
    logic        chroma_flag;
    logic [10:0] video_line;
    logic [11:0] horiz_offset;
    logic        stream_flag;
    logic [6:0]  stream_number;
    logic [9:0]  word_value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             not_empty;
    logic             room2;
  } fifo_stat_t;

endpackage

[hdl/anc_pfp_if.sv]
// Valid/ready channel interfaces for payload bytes and parsed results.
interface anc_pfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       start_of_payload;
  logic       end_of_payload;

  modport source (output valid, payload_byte, start_of_payload, end_of_payload,
                  input ready);
  modport sink (input valid, payload_byte, start_of_payload, end_of_payload,
                output ready);
endinterface

interface anc_pfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [15:0] ext_sequence;
  logic [15:0] payload_length;
  logic [7:0]  packet_count;
  logic [1:0]  field_code;
  logic        chroma_flag;
  logic [10:0] video_line;
  logic [11:0] horiz_offset;
  logic        stream_flag;
  logic [6:0]  stream_number;
  logic [9:0]  word_value;
  logic        last;

  modport source (output valid, item_kind, ext_sequence, payload_length, packet_count,
                  field_code, chroma_flag, video_line, horiz_offset, stream_flag,
                  stream_number, word_value, last,
                  input ready);
  modport sink (input valid, item_kind, ext_sequence, payload_length, packet_count,
                field_code, chroma_flag, video_line, horiz_offset, stream_flag,
                stream_number, word_value, last,
                output ready);
endinterface

[hdl/anc_payload_field_parser.sv]
// Ancillary payload field parser: one payload byte per beat.
// A result is held in the result queue from the cycle after the byte that completes it.
// Throughput: one byte per cycle while at most one result is queued; a byte that gives
// two results (field plus truncation) stalls the input while the three-entry queue drains.
// Reset: synchronous, active low; parser idle, bit buffer and counters cleared, queue empty.
`include "anc_payload_field_parser_assert.svh"

module anc_payload_field_parser (
  input logic         clk,
  input logic         rst_n,
  anc_pfp_in_if.sink  in_chan,
  anc_pfp_out_if.source out_chan
);
  import anc_pfp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LOC,
    ST_DID,
    ST_SDID,
    ST_DC,
    ST_WORDS,
    ST_PAD
  } stage_t;

  localparam logic [6:0] HDR_N  = 7'(HDR_BITS);
  localparam logic [6:0] LOC_N  = 7'(LOC_BITS);
  localparam logic [6:0] WORD_N = 7'(WORD_BITS);

  stage_t      stage_r, stage_nxt;
  logic [63:0] bit_buffer_r, bit_buffer_nxt;
  logic [6:0]  bits_held_r, bits_held_nxt;
  logic [7:0]  packets_left_r, packets_left_nxt;
  logic [7:0]  words_left_r, words_left_nxt;
  logic [4:0]  align_phase_r, align_phase_nxt;

  logic        acc;
  logic [1:0]  res_n;
  res_t [1:0]  res_c;
  res_t        head;
  fifo_stat_t  fifo_stat;

  function automatic logic [63:0] keep_mask(input logic [6:0] sh);
    keep_mask = ~({64{1'b1}} << sh);
  endfunction

  assign acc = in_chan.valid && in_chan.ready;

  // At most one field completes per byte: after any take, fewer bits remain than the
  // next field needs. Only padding can follow a checksum within the same byte.
  always_comb begin
    logic [6:0]  sh;
    logic [31:0] loc;
    logic [9:0]  w;
    logic [4:0]  need;
    logic [4:0]  k;
    logic        r0_v;
    res_t        r0;
    res_t        trunc;

    sh    = '0;
    loc   = '0;
    w     = '0;
    need  = '0;
    k     = '0;
    r0_v  = 1'b0;
    r0    = '0;
    trunc = '0;
    res_c = '0;
    res_n = 2'd0;

    stage_nxt        = stage_r;
    bit_buffer_nxt   = bit_buffer_r;
    bits_held_nxt    = bits_held_r;
    packets_left_nxt = packets_left_r;
    words_left_nxt   = words_left_r;
    align_phase_nxt  = align_phase_r;

    if (acc) begin
      if (in_chan.start_of_payload) begin
        stage_nxt        = ST_HDR;
        bit_buffer_nxt   = '0;
        bits_held_nxt    = '0;
        packets_left_nxt = '0;
        words_left_nxt   = '0;
        align_phase_nxt  = '0;
      end

      if (stage_nxt != ST_IDLE) begin
        bit_buffer_nxt = {bit_buffer_nxt[55:0], in_chan.payload_byte};
        bits_held_nxt  = bits_held_nxt + 7'd8;

        case (stage_nxt)
          ST_HDR: begin
            if (bits_held_nxt >= HDR_N) begin
              r0_v                = 1'b1;
              r0.item_kind        = KIND_HDR;
              r0.ext_sequence     = bit_buffer_nxt[63:48];
              r0.payload_length   = bit_buffer_nxt[47:32];
              r0.packet_count     = bit_buffer_nxt[31:24];
              r0.field_code       = bit_buffer_nxt[RSVD_BITS +: 2];
              r0.last             = (bit_buffer_nxt[31:24] == 8'd0);
              packets_left_nxt    = bit_buffer_nxt[31:24];
              stage_nxt           = r0.last ? ST_IDLE : ST_LOC;
              bit_buffer_nxt      = '0;
              bits_held_nxt       = '0;
            end
          end
          ST_LOC: begin
            if (bits_held_nxt >= LOC_N) begin
              sh                = bits_held_nxt - LOC_N;
              loc               = 32'(bit_buffer_nxt[39:0] >> sh[2:0]);
              bits_held_nxt     = sh;
              bit_buffer_nxt    = bit_buffer_nxt & keep_mask(sh);
              r0_v              = 1'b1;
              r0.item_kind      = KIND_LOC;
              r0.chroma_flag    = loc[31];
              r0.video_line     = loc[30:20];
              r0.horiz_offset   = loc[19:8];
              r0.stream_flag    = loc[7];
              r0.stream_number  = loc[6:0];
              align_phase_nxt   = '0;
              stage_nxt         = ST_DID;
            end
          end
          ST_DID, ST_SDID, ST_DC, ST_WORDS: begin
            if (bits_held_nxt >= WORD_N) begin
              sh              = bits_held_nxt - WORD_N;
              w               = 10'(bit_buffer_nxt[17:0] >> sh[2:0]);
              bits_held_nxt   = sh;
              bit_buffer_nxt  = bit_buffer_nxt & keep_mask(sh);
              align_phase_nxt = align_phase_nxt + 5'(WORD_BITS);
              r0_v            = 1'b1;
              r0.word_value   = w;
              case (stage_nxt)
                ST_DID: begin
                  r0.item_kind = KIND_DID;
                  stage_nxt    = ST_SDID;
                end
                ST_SDID: begin
                  r0.item_kind = KIND_SDID;
                  stage_nxt    = ST_DC;
                end
                ST_DC: begin
                  r0.item_kind   = KIND_DC;
                  words_left_nxt = 8'(w & 10'(BYTE_MASK));
                  stage_nxt      = ST_WORDS;
                end
                default: begin
                  if (words_left_nxt != 8'd0) begin
                    words_left_nxt = words_left_nxt - 8'd1;
                    r0.item_kind   = KIND_USER;
                  end else begin
                    packets_left_nxt = packets_left_nxt - 8'd1;
                    r0.item_kind     = KIND_CSUM;
                    r0.last          = (packets_left_nxt == 8'd0);
                    if (packets_left_nxt == 8'd0) begin
                      stage_nxt = ST_IDLE;
                    end else if (align_phase_nxt == 5'd0) begin
                      stage_nxt = ST_LOC;
                    end else begin
                      stage_nxt = ST_PAD;
                    end
                  end
                end
              endcase
            end
          end
          default: begin
          end
        endcase

        // padding skip, either carried over or right after a checksum
        if (stage_nxt == ST_PAD) begin
          need = 5'(6'(ALIGN_BITS) - {1'b0, align_phase_nxt});
          k    = (bits_held_nxt < {2'b00, need}) ? bits_held_nxt[4:0] : need;
          bits_held_nxt   = bits_held_nxt - {2'b00, k};
          bit_buffer_nxt  = bit_buffer_nxt & keep_mask(bits_held_nxt);
          align_phase_nxt = align_phase_nxt + k;
          if (align_phase_nxt == 5'd0) stage_nxt = ST_LOC;
        end

        trunc.item_kind = KIND_TRUNC;
        trunc.last      = 1'b1;
        if (r0_v) begin
          res_c[0] = r0;
          res_n    = 2'd1;
        end
        if (in_chan.end_of_payload) begin
          if (stage_nxt != ST_IDLE) begin
            if (r0_v) begin
              res_c[1] = trunc;
              res_n    = 2'd2;
            end else begin
              res_c[0] = trunc;
              res_n    = 2'd1;
            end
          end
          stage_nxt      = ST_IDLE;
          bit_buffer_nxt = '0;
          bits_held_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r        <= ST_IDLE;
      bit_buffer_r   <= '0;
      bits_held_r    <= '0;
      packets_left_r <= '0;
      words_left_r   <= '0;
      align_phase_r  <= '0;
    end else begin
      stage_r        <= stage_nxt;
      bit_buffer_r   <= bit_buffer_nxt;
      bits_held_r    <= bits_held_nxt;
      packets_left_r <= packets_left_nxt;
      words_left_r   <= words_left_nxt;
      align_phase_r  <= align_phase_nxt;
    end
  end

  anc_pfp_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push_data (res_c),
    .pop       (out_chan.valid && out_chan.ready),
    .head      (head),
    .stat      (fifo_stat)
  );

  assign in_chan.ready           = fifo_stat.room2;
  assign out_chan.valid          = fifo_stat.not_empty;
  assign out_chan.item_kind      = head.item_kind;
  assign out_chan.ext_sequence   = head.ext_sequence;
  assign out_chan.payload_length = head.payload_length;
  assign out_chan.packet_count   = head.packet_count;
  assign out_chan.field_code     = head.field_code;
  assign out_chan.chroma_flag    = head.chroma_flag;
  assign out_chan.video_line     = head.video_line;
  assign out_chan.horiz_offset   = head.horiz_offset;
  assign out_chan.stream_flag    = head.stream_flag;
  assign out_chan.stream_number  = head.stream_number;
  assign out_chan.word_value     = head.word_value;
  assign out_chan.last           = head.last;

  `ANC_PFP_ASSERT(a_queue_no_overflow, clk, rst_n, int'(res_n) <= (RES_DEPTH - int'(fifo_stat.count)), "result queue overflow")
  `ANC_PFP_ASSERT(a_held_bound, clk, rst_n, bits_held_r <= HDR_N, "bit buffer overfilled")
  `ANC_PFP_IMPLIES(a_pad_phase, clk, rst_n, stage_r == ST_PAD, align_phase_r != 5'd0, "padding with aligned phase")
  `ANC_PFP_NEXT(a_last_idles, clk, rst_n, acc && res_n != 2'd0 && res_c[0].last, stage_r == ST_IDLE, "parser busy after last beat")

endmodule

[hdl/anc_pfp_res_fifo.sv]
// Small result queue: up to two pushes and one pop per cycle.
module anc_pfp_res_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_n,
  input  anc_pfp_pkg::res_t [1:0]  push_data,
  input  logic                     pop,
  output anc_pfp_pkg::res_t        head,
  output anc_pfp_pkg::fifo_stat_t  stat
);
  import anc_pfp_pkg::*;

  res_t             mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr_r] <= push_data[0];
    if (push_n == 2'd2) mem[wr_ptr_p1] <= push_data[1];
  end

  assign head           = mem[rd_ptr_r];
  assign stat.count     = cnt_r;
  assign stat.not_empty = (cnt_r != '0);
  assign stat.room2     = (cnt_r <= CNT_W'(RES_DEPTH - 2));

endmodule
